@@ rtl/sfc_pkg.sv @@
package sfc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int REG_COUNT = 6;
  localparam longint COUNT_MAX = 65535;
  localparam int COUNT_W = $clog2(COUNT_MAX + 1);
  localparam int CFG_INDEX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  localparam int COORD_W = 16;
  localparam int RADIUS_W = 15;
  localparam int TOTAL_W = 16;
  localparam int PROD_W = 32;
  localparam int DR_W = 18;
  localparam int DIST_W = 35;
  localparam int FRAC_SHIFT = 14;

  // register layout: a in the low bits, d in the high bits
  typedef struct packed {
    logic [15:0] d;
    logic [15:0] c;
    logic [15:0] b;
    logic [15:0] a;
  } plane_t;

endpackage

@@ rtl/sphere_frustum_cull_unit.sv @@
// sphere-versus-frustum culling test, one sphere per word
// s_axis: one sphere per word, tdata holds centre x, y, z (signed q8.8) and
//   radius (unsigned q7.8); tlast marks the last sphere of a culling pass
// m_axis: one result per sphere, tdata holds the visible bit and the
//   saturating count of visible spheres so far in the pass; tlast copies
//   the input tlast, the count is final on that word and then clears
// cfg: plane registers 0..5 written with cfg_wen, cfg_index, cfg_data
//   (a, b, c in q2.14 from the low bits, d in q8.8 on top); only while idle
// pipeline: a sphere passes through the input register, the multiplier
//   register of the six plane units and the result register before its
//   result is offered
// throughput: one sphere per cycle while m_axis does not stall; all six planes
//   are tested in parallel and the visible counter updates as each result is registered
// stall: each stage holds while the next is full and stalled, so s_axis_tready drops
//   only once all three stages are occupied behind a stalled m_axis
// reset: clears the stage valids, the visible count and all planes to zero
module sphere_frustum_cull_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [63:0]                     s_axis_tdata,  // center_x, center_y, center_z, sphere_radius
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,  // visible, visible_total
  output logic                            m_axis_tlast,
  input  logic                            cfg_wen,
  input  logic [sfc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data
);

  sfc_pkg::plane_t plane_reg [sfc_pkg::REG_COUNT];

  logic                                in_v;
  logic signed [sfc_pkg::COORD_W-1:0]  in_x;
  logic signed [sfc_pkg::COORD_W-1:0]  in_y;
  logic signed [sfc_pkg::COORD_W-1:0]  in_z;
  logic        [sfc_pkg::RADIUS_W-1:0] in_r;
  logic                                in_last;

  logic s1_v;
  logic s1_last;

  logic                        out_v;
  logic                        out_vis;
  logic [sfc_pkg::TOTAL_W-1:0] out_total;
  logic                        out_last;

  logic [sfc_pkg::COUNT_W-1:0] count;
  logic [sfc_pkg::COUNT_W-1:0] count_next;
  logic [sfc_pkg::COUNT_W+sfc_pkg::TOTAL_W-1:0] count_ext;

  logic s2_ready;
  logic s1_ready;
  logic s1_adv;
  logic s2_adv;
  logic vis;
  logic [sfc_pkg::PLANE_COUNT-1:0] cull;

  assign s2_ready = !out_v || m_axis_tready;
  assign s1_ready = !s1_v || s2_ready;
  assign s_axis_tready = !in_v || s1_ready;
  assign s1_adv = in_v && s1_ready;
  assign s2_adv = s1_v && s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sfc_pkg::REG_COUNT; i++) begin
        plane_reg[i] <= '0;
      end
    end else if (cfg_wen &&
                 (32'(cfg_index) < 32'(sfc_pkg::REG_COUNT))) begin
      plane_reg[cfg_index] <= cfg_data;
    end
  end

  for (genvar p = 0; p < sfc_pkg::PLANE_COUNT; p++) begin : g_plane
    sfc_pkg::plane_t plane;
    // planes without a register stay zero and never cull
    if (p < sfc_pkg::REG_COUNT) begin : g_reg
      assign plane = plane_reg[p];
    end else begin : g_zero
      assign plane = '0;
    end
    sfc_plane_test u_test (
      .clk    (clk),
      .en     (s1_adv),
      .plane  (plane),
      .x      (in_x),
      .y      (in_y),
      .z      (in_z),
      .radius (in_r),
      .cull   (cull[p])
    );
  end

  assign vis = ~|cull;

  always_comb begin
    count_next = count;
    if (vis && (64'(count) < 64'(sfc_pkg::COUNT_MAX))) begin
      count_next = count + sfc_pkg::COUNT_W'(1);
    end
    count_ext = {{sfc_pkg::TOTAL_W{1'b0}}, count_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v  <= 1'b0;
      s1_v  <= 1'b0;
      out_v <= 1'b0;
      count <= '0;
    end else begin
      if (s_axis_tready) begin
        in_v <= s_axis_tvalid;
      end
      if (s1_ready) begin
        s1_v <= in_v;
      end
      if (s2_ready) begin
        out_v <= s1_v;
      end
      if (s2_adv) begin
        count <= s1_last ? '0 : count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_x    <= s_axis_tdata[15:0];
      in_y    <= s_axis_tdata[31:16];
      in_z    <= s_axis_tdata[47:32];
      in_r    <= s_axis_tdata[62:48];
      in_last <= s_axis_tlast;
    end
    if (s1_adv) begin
      s1_last <= in_last;
    end
    if (s2_adv) begin
      out_vis   <= vis;
      out_total <= count_ext[sfc_pkg::TOTAL_W-1:0];
      out_last  <= s1_last;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {7'b0, out_total, out_vis};
  assign m_axis_tlast  = out_last;

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (s2_adv && s1_last) |=> (count == '0))
    else $error("visible count not cleared after end of pass");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    (s2_adv && !s1_last) |=> (count >= $past(count)))
    else $error("visible count decreased within a pass");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_v && s1_v && out_v && !m_axis_tready))
    else $error("input stalled with a free stage");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    s2_adv |=> (64'(count) <= 64'(sfc_pkg::COUNT_MAX)))
    else $error("visible count past saturation");
`endif

endmodule

@@ rtl/sfc_plane_test.sv @@
module sfc_plane_test (
  input  logic                                clk,
  input  logic                                en,
  input  sfc_pkg::plane_t                     plane,
  input  logic signed [sfc_pkg::COORD_W-1:0]  x,
  input  logic signed [sfc_pkg::COORD_W-1:0]  y,
  input  logic signed [sfc_pkg::COORD_W-1:0]  z,
  input  logic        [sfc_pkg::RADIUS_W-1:0] radius,
  output logic                                cull
);

  logic signed [sfc_pkg::PROD_W-1:0] pa;
  logic signed [sfc_pkg::PROD_W-1:0] pb;
  logic signed [sfc_pkg::PROD_W-1:0] pc;
  logic signed [sfc_pkg::DR_W-1:0]   dr;
  logic signed [sfc_pkg::DIST_W-1:0] plane_dist;

  // products and d + r registered, sum and sign test next cycle
  always_ff @(posedge clk) begin
    if (en) begin
      pa <= $signed(plane.a) * x;
      pb <= $signed(plane.b) * y;
      pc <= $signed(plane.c) * z;
      dr <= sfc_pkg::DR_W'($signed(plane.d)) + $signed(sfc_pkg::DR_W'(radius));
    end
  end

  always_comb begin
    plane_dist = sfc_pkg::DIST_W'(pa) + sfc_pkg::DIST_W'(pb) + sfc_pkg::DIST_W'(pc)
               + (sfc_pkg::DIST_W'(dr) <<< sfc_pkg::FRAC_SHIFT);
    cull = plane_dist[sfc_pkg::DIST_W-1];
  end

endmodule

@@ test/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfc_pkg::*;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PLANE_0, REG_PLANE_1, REG_PLANE_2, REG_PLANE_3, REG_PLANE_4, REG_PLANE_5,
    REG_SPARE_A, REG_SPARE_B
  } reg_index_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [RADIUS_W-1:0]       radius;
    logic                      last;
  } sphere_t;

  typedef struct packed {
    logic               vis;
    logic [TOTAL_W-1:0] total;
    logic               done;
  } cull_result_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [63:0]            s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [23:0]            m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_wen;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [63:0]            cfg_data;

  // predictor copy of the plane registers and the per-pass visible count
  plane_t       plane_regs [REG_COUNT];
  longint       visible_run;
  cull_result_t pending_results [$];
  cull_result_t want;
  int           mismatch_count;
  bit           no_idle;

  sphere_frustum_cull_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= 21);
  end

  function automatic plane_t make_plane(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                        logic [15:0] d);
    plane_t pl;
    pl.a = a;
    pl.b = b;
    pl.c = c;
    pl.d = d;
    return pl;
  endfunction

  function automatic sphere_t make_sphere(int x, int y, int z, int r, bit last);
    sphere_t s;
    s.cx = COORD_W'(x);
    s.cy = COORD_W'(y);
    s.cz = COORD_W'(z);
    s.radius = RADIUS_W'(r);
    s.last = last;
    return s;
  endfunction

  // near spheres sit around the origin where typical planes cut through them
  function automatic sphere_t random_sphere(bit near, bit last);
    sphere_t s;
    if (near) begin
      s = make_sphere(int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048,
                      int'($urandom_range(4095)) - 2048, $urandom_range(1023), last);
    end else begin
      s = make_sphere($urandom, $urandom, $urandom, $urandom, last);
    end
    return s;
  endfunction

  // exact q.22 plane distance plus scaled radius; culled when below zero
  function automatic bit sphere_culled(plane_t pl, sphere_t s);
    longint dist_q22;
    dist_q22 = longint'($signed(pl.a)) * longint'($signed(s.cx))
             + longint'($signed(pl.b)) * longint'($signed(s.cy))
             + longint'($signed(pl.c)) * longint'($signed(s.cz))
             + (longint'($signed(pl.d)) <<< FRAC_SHIFT);
    return (dist_q22 + (longint'(s.radius) <<< FRAC_SHIFT)) < 0;
  endfunction

  function automatic cull_result_t predict_cull(sphere_t s);
    cull_result_t res;
    bit seen;
    seen = 1'b1;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      if (p < REG_COUNT && sphere_culled(plane_regs[p], s)) seen = 1'b0;
    end
    if (seen && visible_run < COUNT_MAX) visible_run++;
    res.vis = seen;
    res.total = visible_run[TOTAL_W-1:0];
    res.done = s.last;
    if (s.last) visible_run = 0;
    return res;
  endfunction

  // leaves tvalid high so back-to-back words need no second assignment in one step
  task automatic send_sphere(sphere_t s);
    int gap;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(99) < 21) gap++;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, s.radius, s.cz, s.cy, s.cx};
    s_axis_tlast <= s.last;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_cull(s));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_plane(reg_index_t idx, plane_t val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    if (int'(idx) < REG_COUNT) plane_regs[int'(idx)] = val;
  endtask

  // planes at reset are all zero, so every sphere should pass
  task automatic test_zero_planes();
    send_sphere(make_sphere(32767, 32767, 32767, 32767, 1'b0));
    send_sphere(make_sphere(-32768, -32768, -32768, 0, 1'b0));
    send_sphere(make_sphere(0, 0, 0, 0, 1'b1));
    send_sphere(make_sphere(-32768, 32767, -1, 16384, 1'b0));
    send_sphere(make_sphere(1, -1, 32767, 1, 1'b1));
    wait_drained();
  endtask

  task automatic test_plane_edges();
    write_plane(REG_PLANE_0, make_plane(16'h4000, 16'h0000, 16'h0000, 16'h0000));
    // writes past the register list must leave the planes alone
    write_plane(REG_SPARE_A, make_plane(16'h4000, 16'h0000, 16'h0000, 16'h8000));
    write_plane(REG_SPARE_B, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sphere(make_sphere(-256, 0, 0, 256, 1'b0));   // just touching
    send_sphere(make_sphere(-256, 0, 0, 255, 1'b0));
    send_sphere(make_sphere(-257, 0, 0, 256, 1'b0));
    send_sphere(make_sphere(0, 0, 0, 0, 1'b0));
    send_sphere(make_sphere(32767, 0, 0, 0, 1'b0));
    send_sphere(make_sphere(-32768, 0, 0, 32767, 1'b1));
    wait_drained();
    write_plane(REG_PLANE_1, 64'hFFFF_FFFF_FFFF_FFFF);
    write_plane(REG_PLANE_2, 64'h7FFF_7FFF_7FFF_7FFF);
    write_plane(REG_PLANE_3, 64'h8000_8000_8000_8000);
    write_plane(REG_PLANE_5, make_plane(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
    send_sphere(make_sphere(32767, 32767, 32767, 32767, 1'b0));
    send_sphere(make_sphere(-32768, -32768, -32768, 32767, 1'b0));
    send_sphere(make_sphere(32767, -32768, 32767, 0, 1'b0));
    send_sphere(make_sphere(0, 0, 0, 32767, 1'b0));
    send_sphere(make_sphere(0, 0, 0, 0, 1'b1));
    send_sphere(make_sphere(-1, -1, -1, 32767, 1'b1));
    wait_drained();
  endtask

  // one long pass with all planes at zero keeps every sphere visible, then a one-sphere pass
  task automatic test_long_pass();
    for (int i = 0; i < REG_COUNT; i++) write_plane(reg_index_t'(i), '0);
    for (int n = 0; n < 228; n++) begin
      send_sphere(random_sphere($urandom_range(1) != 0, 1'b0));
    end
    send_sphere(random_sphere(1'b1, 1'b1));
    send_sphere(random_sphere(1'b1, 1'b1));
    wait_drained();
  endtask

  task automatic test_random_passes();
    plane_t pl;
    for (int phase = 0; phase < 10; phase++) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        case ($urandom_range(3))
          0: pl = '0;
          1: pl = {$urandom, $urandom};
          default: pl = make_plane(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom_range(16'h1000)));
        endcase
        write_plane(reg_index_t'(i), pl);
      end
      if (phase % 3 == 0) write_plane($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                                      {$urandom, $urandom});
      no_idle = (phase == 4);
      for (int n = 0; n < 120; n++) begin
        send_sphere(random_sphere($urandom_range(9) < 7, $urandom_range(15) == 0));
      end
      // sender holds off until the pipeline has emptied
      wait_drained();
      no_idle = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing expected, tdata %h tlast %b",
                 $time, m_axis_tdata, m_axis_tlast);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[0] !== want.vis) begin
          $display("%0t: visible expected %b actual %b", $time, want.vis, m_axis_tdata[0]);
          mismatch_count++;
        end
        if (m_axis_tdata[16:1] !== want.total) begin
          $display("%0t: visible_total expected %0d actual %0d",
                   $time, want.total, m_axis_tdata[16:1]);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.done) begin
          $display("%0t: pass_done expected %b actual %b", $time, want.done, m_axis_tlast);
          mismatch_count++;
        end
        if (m_axis_tdata[23:17] !== '0) begin
          $display("%0t: tdata padding expected 0 actual %h", $time, m_axis_tdata[23:17]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    cfg_wen = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    no_idle = 1'b0;
    mismatch_count = 0;
    visible_run = 0;
    for (int i = 0; i < REG_COUNT; i++) plane_regs[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero_planes();
    test_plane_edges();
    test_long_pass();
    test_random_passes();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
